>>> design/sco_pkg.sv
// Shared types and constants of the steering command optimiser.
package sco_pkg;

    // Width of the quotient that the divider produces below the overflow point.
    localparam int QUO_W = 32;

    // Quotient bits resolved in each divider stage.
    localparam int STEP_BITS = 2;

    // Number of divider stages.
    localparam int STAGES = QUO_W / STEP_BITS;

    // Pipeline from the accepting edge to the edge that transfers the result:
    // input stage, limit stage, divider stages and output register.
    localparam int LATENCY = STAGES + 3;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ANGLE_LOW    = 2'd0,
        REG_ANGLE_HIGH   = 2'd1,
        REG_WHEEL_RADIUS = 2'd2,
        REG_RATE_LIMIT   = 2'd3
    } sco_reg_t;

    // Side information that travels alongside the quotient through the divider.
    typedef struct packed {
        logic        rzero;
        logic        ovf;
        logic        neg;
        logic [15:0] angle;
    } sco_tag_t;

endpackage

>>> design/steer_command_optimizer.sv
// Throughput: one command per clock cycle; busy stays low and nothing stalls.
// The pipeline holds the 16-stage divider, two quotient bits per stage,
// plus an input stage, an angle limit stage and the output register.
// Reset clears the pipeline valid bits and returns the registers to their
// defaults: both angle limits zero, wheel radius 1.0 and no rate limit.
module steer_command_optimizer
#(
    parameter int TURN_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] angle_cmd,
    input  logic signed [31:0] speed_cmd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [15:0] steer_angle,
    output logic signed [31:0] wheel_rate,
    output logic               radius_error
);

    localparam int AW = ((TURN_BITS > 16) ? TURN_BITS : 16) + 2;
    localparam logic signed [AW-1:0] PI_C      = AW'(2 ** (TURN_BITS - 1));
    localparam logic signed [AW-1:0] HALF_PI_C = AW'(2 ** (TURN_BITS - 2));

    // Configuration registers.
    logic signed [15:0] angle_low_reg;
    logic signed [15:0] angle_high_reg;
    logic [31:0]        radius_reg;
    logic [30:0]        rate_limit_reg;

    // Input stage.
    logic                 v1_reg;
    logic signed [AW-1:0] a1_reg;
    logic signed [AW-1:0] a1_next;
    logic                 neg1_reg;
    logic                 neg1_next;
    logic [31:0]          mag1_reg;
    logic [31:0]          mag1_next;

    // Limit stage.
    logic                 v2_reg;
    logic [31:0]          rem2_reg;
    logic [31:0]          dvd2_reg;
    sco_pkg::sco_tag_t    tag2_reg;
    sco_pkg::sco_tag_t    tag2_next;

    // Divider output.
    logic                 dv_valid;
    logic [31:0]          dv_quo;
    sco_pkg::sco_tag_t    dv_tag;

    // Output stage.
    logic                 done_reg;
    logic signed [15:0]   angle_out_reg;
    logic signed [15:0]   angle_out_next;
    logic [31:0]          rate_out_reg;
    logic [31:0]          rate_out_next;
    logic                 err_out_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_low_reg  <= 16'sd0;
            angle_high_reg <= 16'sd0;
            radius_reg     <= 32'h0001_0000;
            rate_limit_reg <= 31'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (sco_pkg::sco_reg_t'(cfg_index))
                sco_pkg::REG_ANGLE_LOW:    angle_low_reg  <= cfg_data[15:0];
                sco_pkg::REG_ANGLE_HIGH:   angle_high_reg <= cfg_data[15:0];
                sco_pkg::REG_WHEEL_RADIUS: radius_reg     <= cfg_data;
                sco_pkg::REG_RATE_LIMIT:   rate_limit_reg <= cfg_data[30:0];
                default:                   radius_reg     <= radius_reg;
            endcase
        end
    end

    // Wrap the angle to one turn, fold it to the front half and take |speed|.
    always_comb
    begin
        a1_next   = {{(AW-TURN_BITS){angle_cmd[TURN_BITS-1]}}, angle_cmd[TURN_BITS-1:0]};
        neg1_next = 1'b0;
        if (a1_next >= HALF_PI_C)
        begin
            a1_next   = a1_next - PI_C;
            neg1_next = 1'b1;
        end
        else if (a1_next <= -HALF_PI_C)
        begin
            a1_next   = a1_next + PI_C;
            neg1_next = 1'b1;
        end
        if (speed_cmd < 0)
        begin
            mag1_next = 32'(33'd0 - 33'(speed_cmd));
            neg1_next = !neg1_next;
        end
        else
        begin
            mag1_next = speed_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg   <= a1_next;
        neg1_reg <= neg1_next;
        mag1_reg <= mag1_next;
    end

    // Apply the angle limits and prepare the division operands.
    always_comb
    begin
        logic signed [AW-1:0] a;
        logic signed [AW-1:0] lo;
        logic signed [AW-1:0] hi;
        logic                 neg;
        a   = a1_reg;
        neg = neg1_reg;
        lo  = AW'(angle_low_reg);
        hi  = AW'(angle_high_reg);
        if (hi != lo)
        begin
            if (a > hi)
            begin
                a   = a - PI_C;
                neg = !neg;
            end
            else if (a < lo)
            begin
                a   = a + PI_C;
                neg = !neg;
            end
            if (a > hi)
            begin
                a = hi;
            end
            else if (a < lo)
            begin
                a = lo;
            end
        end
        tag2_next.rzero = (radius_reg == 32'd0);
        tag2_next.ovf   = ({16'd0, mag1_reg[31:16]} >= radius_reg);
        tag2_next.neg   = neg;
        tag2_next.angle = a[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    // The high half of (speed << 16) is the starting remainder.
    always_ff @(posedge clk)
    begin
        rem2_reg <= {16'd0, mag1_reg[31:16]};
        dvd2_reg <= {mag1_reg[15:0], 16'd0};
        tag2_reg <= tag2_next;
    end

    sco_div_pipe u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .in_rem    (rem2_reg),
        .in_dvd    (dvd2_reg),
        .in_tag    (tag2_reg),
        .divisor   (radius_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // Rate limit, sign and saturation of the quotient; a zero radius zeroes both outputs.
    always_comb
    begin
        logic [32:0] qx;
        qx = dv_tag.ovf ? 33'h1_0000_0000 : {1'b0, dv_quo};
        if (rate_limit_reg != 31'd0 && qx > {2'b00, rate_limit_reg})
        begin
            qx = {2'b00, rate_limit_reg};
        end
        if (qx == 33'd0)
        begin
            rate_out_next = 32'd0;
        end
        else if (dv_tag.neg)
        begin
            if (qx > 33'h0_8000_0000)
            begin
                rate_out_next = 32'h8000_0000;
            end
            else
            begin
                rate_out_next = 32'(33'd0 - qx);
            end
        end
        else
        begin
            if (qx > 33'h0_7FFF_FFFF)
            begin
                rate_out_next = 32'h7FFF_FFFF;
            end
            else
            begin
                rate_out_next = qx[31:0];
            end
        end
        angle_out_next = dv_tag.angle;
        if (dv_tag.rzero)
        begin
            rate_out_next  = 32'd0;
            angle_out_next = 16'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_out_reg <= angle_out_next;
        rate_out_reg  <= rate_out_next;
        err_out_reg   <= dv_tag.rzero;
    end

    assign done         = done_reg;
    assign steer_angle  = angle_out_reg;
    assign wheel_rate   = rate_out_reg;
    assign radius_error = err_out_reg;

endmodule

>>> design/sco_div_pipe.sv
// Pipelined restoring divider producing a 32-bit quotient, two bits per stage.
module sco_div_pipe
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [31:0]       in_rem,
    input  logic [31:0]       in_dvd,
    input  sco_pkg::sco_tag_t in_tag,
    input  logic [31:0]       divisor,
    output logic              out_valid,
    output logic [31:0]       out_quo,
    output sco_pkg::sco_tag_t out_tag
);

    localparam int STAGES = sco_pkg::STAGES;
    localparam int STEP   = sco_pkg::STEP_BITS;

    logic [STAGES-1:0]  vld_reg;
    logic [31:0]        rem_reg [STAGES];
    logic [31:0]        dvd_reg [STAGES];
    logic [31:0]        quo_reg [STAGES];
    sco_pkg::sco_tag_t  tag_reg [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic              vld_src;
        logic [31:0]       rem_src;
        logic [31:0]       dvd_src;
        logic [31:0]       quo_src;
        sco_pkg::sco_tag_t tag_src;
        logic [31:0]       rem_next;
        logic [31:0]       dvd_next;
        logic [31:0]       quo_next;
        logic [32:0]       trial;
        logic              qbit;

        // The first stage takes the operands, later ones the previous stage.
        if (g == 0) begin : g_first
            assign vld_src = in_valid;
            assign rem_src = in_rem;
            assign dvd_src = in_dvd;
            assign quo_src = 32'd0;
            assign tag_src = in_tag;
        end
        else begin : g_next
            assign vld_src = vld_reg[g-1];
            assign rem_src = rem_reg[g-1];
            assign dvd_src = dvd_reg[g-1];
            assign quo_src = quo_reg[g-1];
            assign tag_src = tag_reg[g-1];
        end

        // Shift in one dividend bit at a time and subtract where it fits.
        always_comb
        begin
            rem_next = rem_src;
            dvd_next = dvd_src;
            quo_next = quo_src;
            trial    = 33'd0;
            qbit     = 1'b0;
            for (int b = 0; b < STEP; b++)
            begin
                trial = {rem_next, dvd_next[31]};
                if (trial >= {1'b0, divisor})
                begin
                    rem_next = 32'(trial - {1'b0, divisor});
                    qbit     = 1'b1;
                end
                else
                begin
                    rem_next = trial[31:0];
                    qbit     = 1'b0;
                end
                dvd_next = {dvd_next[30:0], 1'b0};
                quo_next = {quo_next[30:0], qbit};
            end
        end

        // Stage valid bit.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[g] <= 1'b0;
            end
            else
            begin
                vld_reg[g] <= vld_src;
            end
        end

        // Stage payload.
        always_ff @(posedge clk)
        begin
            rem_reg[g] <= rem_next;
            dvd_reg[g] <= dvd_next;
            quo_reg[g] <= quo_next;
            tag_reg[g] <= tag_src;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_quo   = quo_reg[STAGES-1];
    assign out_tag   = tag_reg[STAGES-1];

endmodule

>>> design/sco_checker.sv
// Port-level checks of the steering command optimiser and their binding.
module sco_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] steer_angle,
    input logic signed [31:0] wheel_rate,
    input logic               radius_error
);

    // Every accepted command is followed by a transferred result.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(sco_pkg::LATENCY) done)
        else $error("accepted command produced no result");

    // No result transfers without a matching accepted command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, sco_pkg::LATENCY))
        else $error("result without a matching command");

    // A zero radius gives zero outputs.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && radius_error) |-> (steer_angle == 16'sd0 && wheel_rate == 32'sd0))
        else $error("radius error with nonzero outputs");

endmodule

bind steer_command_optimizer sco_checker u_sco_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .steer_angle  (steer_angle),
    .wheel_rate   (wheel_rate),
    .radius_error (radius_error)
);
